/* rtl/assert_macros.svh */
// shared assertion macros, clocked by i_clk, idle during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FVC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define FVC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* rtl/fvc_pkg.sv */
package fvc_pkg;

    localparam int MAX_TAPS_DEF    = 7;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int OUT_W           = 35;
    localparam int COEF_W          = 16;
    localparam int TAP_W           = 3;
    localparam int NUM_COEF        = 7;
    localparam int REG_W           = 32;
    localparam int PADDR_W         = 5;
    localparam int REG_IDX_W       = 3;

    localparam logic [COEF_W-1:0] COEF0_RESET = 16'd16384;
    localparam logic [TAP_W-1:0]  TAPS_RESET  = 3'd1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TAP_COUNT = 3'd0,
        REG_COEF_0    = 3'd1,
        REG_COEF_1    = 3'd2,
        REG_COEF_2    = 3'd3,
        REG_COEF_3    = 3'd4,
        REG_COEF_4    = 3'd5,
        REG_COEF_5    = 3'd6,
        REG_COEF_6    = 3'd7
    } t_reg_idx;

    // effective tap count (already clamped) and the tap weights
    typedef struct packed {
        logic [TAP_W-1:0]                taps;
        logic [NUM_COEF-1:0][COEF_W-1:0] coef;
    } t_cfg;

endpackage

/* rtl/fvc_in_if.sv */
interface fvc_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          row_start;

    modport source (output valid, output sample, output row_start, input ready);
    modport sink   (input valid, input sample, input row_start, output ready);
endinterface

/* rtl/fvc_out_if.sv */
interface fvc_out_if;
    logic               valid;
    logic               ready;
    logic signed [34:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

/* rtl/fvc_cfg.sv */
module fvc_cfg
    import fvc_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]   pwdata,
    output logic [REG_W-1:0]   prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [TAP_W-1:0]  r_tap_count;
    logic [COEF_W-1:0] r_coef [NUM_COEF];
    t_reg_idx          w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAPS_RESET;
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= (i == 0) ? COEF0_RESET : '0;
            end
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TAP_COUNT: r_tap_count <= pwdata[TAP_W-1:0];
                default:       r_coef[REG_IDX_W'(w_idx - REG_COEF_0)] <= pwdata[COEF_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TAP_COUNT: prdata = REG_W'(r_tap_count);
            default:       prdata = REG_W'($signed(r_coef[REG_IDX_W'(w_idx - REG_COEF_0)]));
        endcase
    end

    // zero acts as one tap, above the chain length acts as the full chain
    always_comb begin
        if (r_tap_count == '0) begin
            o_cfg.taps = TAP_W'(1);
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            o_cfg.taps = TAP_W'(MAX_TAPS);
        end else begin
            o_cfg.taps = r_tap_count;
        end
        for (int i = 0; i < NUM_COEF; i++) begin
            o_cfg.coef[i] = r_coef[i];
        end
    end

endmodule

/* rtl/fvc_cell.sv */
module fvc_cell
    import fvc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    logic signed [SAMPLE_BITS-1:0] r_sample;

    assign o_sample = r_sample;

    // window sample moves one cell further from the head on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_en) begin
            r_sample <= i_sample;
        end
    end

endmodule

/* rtl/fvc_obuf.sv */
`include "assert_macros.svh"

module fvc_obuf
    import fvc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic signed [OUT_W-1:0] i_data,
    output logic                    o_room,
    fvc_out_if.source               o_out
);

    logic                    r_out_valid;
    logic                    n_out_valid;
    logic signed [OUT_W-1:0] r_out_data;
    logic signed [OUT_W-1:0] n_out_data;
    logic                    r_skid_valid;
    logic                    n_skid_valid;
    logic signed [OUT_W-1:0] r_skid_data;
    logic signed [OUT_W-1:0] n_skid_data;
    logic                    w_take;

    assign w_take         = r_out_valid & o_out.ready;
    assign o_room         = ~r_skid_valid;
    assign o_out.valid    = r_out_valid;
    assign o_out.filtered = r_out_data;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (w_take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (i_push) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    `FVC_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    `FVC_ASSERT_NOW(a_push_has_room, i_push, o_room)
    `FVC_ASSERT_NEXT(a_skid_refills_out, w_take && r_skid_valid, r_out_valid && !r_skid_valid)

endmodule

/* rtl/fir_valid_correlation.sv */
// channel   dir   handshake      payload
// i_in      in    valid/ready    sample, row_start
// o_out     out   valid/ready    filtered
// apb       in    psel/penable   tap_count, coef_0..coef_6
//
// one sample per cycle while the output buffer has room; a result is registered in the output buffer on its beat
// the sample window shifts through a row of cells on each accepted beat and
// every tap product of the current window feeds a balanced adder tree
// a two-entry output buffer keeps i_in ready while one result is stalled
// reset clears the fill count, the window and the output buffer; the tap count resets to one

module fir_valid_correlation
    import fvc_pkg::*;
#(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fvc_in_if.sink             i_in,
    fvc_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]   pwdata,
    output logic [REG_W-1:0]   prdata,
    output logic               pready
);

    localparam int ACC_W    = SAMPLE_BITS + COEF_W + 3;
    localparam int PROD_W   = SAMPLE_BITS + COEF_W;
    localparam int FILL_W   = $clog2(MAX_TAPS + 1);
    localparam int FILL_MAX = MAX_TAPS - 1;
    localparam int TREE_LVL = $clog2(MAX_TAPS);
    localparam int TREE_N   = 1 << TREE_LVL;

    t_cfg                          w_cfg;
    logic                          w_room;
    logic                          w_accept;
    logic                          w_produce;
    logic [FILL_W-1:0]             r_fill;
    logic [FILL_W-1:0]             n_fill;
    logic [FILL_W-1:0]             w_fill_eff;
    logic signed [SAMPLE_BITS-1:0] w_win  [MAX_TAPS];
    logic signed [ACC_W-1:0]       w_node [1:2*TREE_N-1];

    fvc_cfg #(
        .MAX_TAPS (MAX_TAPS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign i_in.ready = w_room;
    assign w_accept   = i_in.valid & w_room;

    // row start restarts the count before this sample is counted
    assign w_fill_eff = i_in.row_start ? '0 : r_fill;
    assign w_produce  = (32'(w_fill_eff) + 1) >= 32'(w_cfg.taps);

    always_comb begin
        n_fill = r_fill;
        if (w_accept) begin
            n_fill = (32'(w_fill_eff) < FILL_MAX) ? w_fill_eff + FILL_W'(1) : w_fill_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // entry 0 is the incoming sample, entry a the a-th newest earlier one
    assign w_win[0] = i_in.sample;

    for (genvar j = 1; j < MAX_TAPS; j++) begin : g_cell
        fvc_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_accept),
            .i_sample (w_win[j-1]),
            .o_sample (w_win[j])
        );
    end

    // the newest sample takes the last tap in use, taps past the count add nothing
    for (genvar a = 0; a < TREE_N; a++) begin : g_term
        if (a < MAX_TAPS) begin : g_tap
            logic signed [COEF_W-1:0] w_c;
            logic signed [PROD_W-1:0] w_prod;

            always_comb begin
                if (TAP_W'(a) < w_cfg.taps) begin
                    w_c = $signed(w_cfg.coef[w_cfg.taps - TAP_W'(a) - TAP_W'(1)]);
                end else begin
                    w_c = '0;
                end
            end

            assign w_prod               = w_c * w_win[a];
            assign w_node[TREE_N + a] = ACC_W'(w_prod);
        end else begin : g_pad
            assign w_node[TREE_N + a] = '0;
        end
    end

    for (genvar n = 1; n < TREE_N; n++) begin : g_add
        assign w_node[n] = w_node[2*n] + w_node[2*n+1];
    end

    fvc_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept & w_produce),
        .i_data  (OUT_W'(w_node[1])),
        .o_room  (w_room),
        .o_out   (o_out)
    );

endmodule
